### design/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared constants, register codes and types of the masked byte pattern scan.
// ----------------------------------------------------------------------------
package mbps_pkg;

    // window depth and derived widths
    localparam int PATTERN_MAX = 32;
    localparam int IDX_W       = $clog2(PATTERN_MAX);
    localparam int LEN_W       = $clog2(PATTERN_MAX) + 1;

    // stream and configuration widths
    localparam int S_TDATA_W   = 8;
    localparam int OFFSET_W    = 32;
    localparam int WORD_W      = 16;
    localparam int M_TDATA_W   = ((OFFSET_W + WORD_W + 7) / 8) * 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_0      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_1      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_2      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_3      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CARE_NIBBLES   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_ADJUST  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_OFFSET = 3'd7;

    // pattern aligned to window taps, tap 0 holds the newest byte
    typedef struct packed {
        logic [PATTERN_MAX-1:0][7:0] tap_pattern;
        logic [PATTERN_MAX-1:0][7:0] tap_mask;
        logic [PATTERN_MAX-1:0]      cap_lo_sel;
        logic [PATTERN_MAX-1:0]      cap_hi_sel;
        logic [LEN_W-1:0]            length;
        logic [OFFSET_W-1:0]         offset_adj;
    } mbps_align_t;

    // one result item
    typedef struct packed {
        logic [WORD_W-1:0]   captured_word;
        logic [OFFSET_W-1:0] match_offset;
        logic                found;
    } mbps_result_t;

endpackage

### design/mbps_cfg.sv
// ----------------------------------------------------------------------------
// mbps_cfg
// Configuration registers and the registered tap-aligned form of the pattern,
// care mask, capture selects and offset adjustment.
// ----------------------------------------------------------------------------
module mbps_cfg
    import mbps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output mbps_align_t           align
);

    logic [3:0][63:0] pattern_word_reg;
    logic [63:0]      care_nibbles_reg;
    logic [5:0]       pattern_length_reg;
    logic [4:0]       report_adjust_reg;
    logic [4:0]       capture_offset_reg;

    mbps_align_t      align_reg;
    mbps_align_t      align_next;

    logic [255:0]                pattern_all;
    logic [PATTERN_MAX-1:0][7:0] pattern_bytes;
    logic [LEN_W-1:0]            len_eff;
    logic [LEN_W-1:0]            cap_pos;
    logic [LEN_W-1:0]            lo_tap;
    logic [LEN_W-1:0]            hi_tap;
    logic                        lo_ok;
    logic                        hi_ok;
    logic [IDX_W-1:0]            pat_idx;

    assign cfg_ready = 1'b1;
    assign align     = align_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_word_reg   <= '0;
            care_nibbles_reg   <= '0;
            pattern_length_reg <= 6'd1;
            report_adjust_reg  <= '0;
            capture_offset_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PATTERN_0:      pattern_word_reg[0] <= cfg_data;
                REG_PATTERN_1:      pattern_word_reg[1] <= cfg_data;
                REG_PATTERN_2:      pattern_word_reg[2] <= cfg_data;
                REG_PATTERN_3:      pattern_word_reg[3] <= cfg_data;
                REG_CARE_NIBBLES:   care_nibbles_reg    <= cfg_data;
                REG_PATTERN_LENGTH: pattern_length_reg  <= cfg_data[5:0];
                REG_REPORT_ADJUST:  report_adjust_reg   <= cfg_data[4:0];
                REG_CAPTURE_OFFSET: capture_offset_reg  <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // effective length, clamped to 1..PATTERN_MAX
    always_comb begin
        if (pattern_length_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (LEN_W'(pattern_length_reg) > LEN_W'(PATTERN_MAX)) begin
            len_eff = LEN_W'(PATTERN_MAX);
        end else begin
            len_eff = LEN_W'(pattern_length_reg);
        end
    end

    assign pattern_all   = pattern_word_reg;
    assign pattern_bytes = pattern_all[PATTERN_MAX*8-1:0];

    // capture taps: pattern position p sits at tap len-1-p
    assign cap_pos = LEN_W'(capture_offset_reg);
    assign lo_ok   = cap_pos < len_eff;
    assign hi_ok   = (cap_pos + LEN_W'(1)) < len_eff;
    assign lo_tap  = len_eff - LEN_W'(1) - cap_pos;
    assign hi_tap  = len_eff - LEN_W'(2) - cap_pos;

    // align pattern and care mask to taps, taps past the length never compare
    always_comb begin
        align_next = '0;
        pat_idx    = '0;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            if (LEN_W'(j) < len_eff) begin
                pat_idx = IDX_W'(len_eff - LEN_W'(j) - LEN_W'(1));
                align_next.tap_pattern[j] = pattern_bytes[pat_idx];
                align_next.tap_mask[j] = {{4{care_nibbles_reg[{pat_idx, 1'b1}]}},
                                          {4{care_nibbles_reg[{pat_idx, 1'b0}]}}};
            end
            align_next.cap_lo_sel[j] = lo_ok && (lo_tap == LEN_W'(j));
            align_next.cap_hi_sel[j] = hi_ok && (hi_tap == LEN_W'(j));
        end
        align_next.length     = len_eff;
        align_next.offset_adj = OFFSET_W'(report_adjust_reg) - OFFSET_W'(len_eff)
                                + OFFSET_W'(1);
    end

    // aligned copy, registered from the configuration registers
    always_ff @(posedge aclk) begin
        align_reg <= align_next;
    end

endmodule

### design/mbps_scan.sv
// ----------------------------------------------------------------------------
// mbps_scan
// Byte window shift line, one item stage and the flat masked compare that
// decides the result of the item held in that stage.
// ----------------------------------------------------------------------------
module mbps_scan
    import mbps_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_accept,
    input  logic [7:0]   in_byte,
    input  logic         in_last,
    input  logic         retire,
    input  mbps_align_t  align,
    output logic         item_valid,
    output logic         res_valid,
    output mbps_result_t result
);

    logic [7:0]          win_reg [PATTERN_MAX];
    logic                item_valid_reg;
    logic                item_last_reg;
    logic [OFFSET_W-1:0] pos_reg;
    logic [OFFSET_W-1:0] pos_next;
    logic [LEN_W-1:0]    fill_reg;
    logic [LEN_W-1:0]    fill_next;
    logic [LEN_W-1:0]    fill_eff;
    logic                done_reg;
    logic                done_next;

    logic [PATTERN_MAX-1:0] tap_ok;
    logic                   hit;
    logic [7:0]             cap_lo;
    logic [7:0]             cap_hi;

    assign item_valid = item_valid_reg;

    // window shift line, newest byte at tap 0
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            win_reg[0] <= in_byte;
            for (int j = 1; j < PATTERN_MAX; j++) begin
                win_reg[j] <= win_reg[j-1];
            end
        end
    end

    // item stage holds the last flag of the byte at tap 0
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (in_accept) begin
            item_valid_reg <= 1'b1;
        end else if (retire) begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            item_last_reg <= in_last;
        end
    end

    // window fill including the byte in the item stage
    assign fill_eff = (fill_reg == LEN_W'(PATTERN_MAX)) ? fill_reg : fill_reg + LEN_W'(1);

    // masked compare of every tap
    always_comb begin
        for (int j = 0; j < PATTERN_MAX; j++) begin
            tap_ok[j] = ((win_reg[j] ^ align.tap_pattern[j]) & align.tap_mask[j]) == 8'h00;
        end
    end

    // captured bytes picked by one-hot tap selects
    always_comb begin
        cap_lo = '0;
        cap_hi = '0;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            cap_lo = cap_lo | (win_reg[j] & {8{align.cap_lo_sel[j]}});
            cap_hi = cap_hi | (win_reg[j] & {8{align.cap_hi_sel[j]}});
        end
    end

    assign hit       = item_valid_reg && !done_reg && (fill_eff >= align.length) && (&tap_ok);
    assign res_valid = hit || (item_valid_reg && item_last_reg && !done_reg);

    // result fields, zero on a not-found result
    always_comb begin
        result = '0;
        if (hit) begin
            result.found         = 1'b1;
            result.match_offset  = pos_reg + align.offset_adj;
            result.captured_word = {cap_hi, cap_lo};
        end
    end

    // region state, rearmed after the last byte
    always_comb begin
        if (item_last_reg) begin
            pos_next  = '0;
            fill_next = '0;
            done_next = 1'b0;
        end else begin
            pos_next  = pos_reg + OFFSET_W'(1);
            fill_next = fill_eff;
            done_next = done_reg || hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            fill_reg <= '0;
            done_reg <= 1'b0;
        end else if (retire) begin
            pos_reg  <= pos_next;
            fill_reg <= fill_next;
            done_reg <= done_next;
        end
    end

endmodule

### design/masked_byte_pattern_scan.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan
// First-match search of a wildcard byte pattern of up to 32 bytes over a byte
// stream, one region per tlast-terminated run.
// ----------------------------------------------------------------------------
// Each result is registered as its byte leaves the item stage. Throughput:
// one byte per cycle unless a result waits on a stalled output; the window
// compare is one flat stage between the item stage and the output register.
// Configuration writes take effect for bytes accepted from the next cycle on.
// Reset: synchronous, active low; clears the registers to their defaults,
// empties both stages and rearms the search. No clearing pass is needed.
module masked_byte_pattern_scan
    import mbps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input bytes
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // byte_value [7:0]
    input  logic                  s_tlast,   // last_byte
    // results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic                  m_tuser,   // found
    output logic [M_TDATA_W-1:0]  m_tdata,   // match_offset [31:0],
                                             // captured_word [47:32]
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    mbps_align_t  align;
    mbps_result_t result;
    logic         item_valid;
    logic         res_valid;
    logic         retire;
    logic         in_accept;
    logic         load;

    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic                 m_tuser_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    mbps_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .align     (align)
    );

    mbps_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .in_byte    (s_tdata[7:0]),
        .in_last    (s_tlast),
        .retire     (retire),
        .align      (align),
        .item_valid (item_valid),
        .res_valid  (res_valid),
        .result     (result)
    );

    // item stage moves on unless its result finds the output register full and stalled
    assign retire    = item_valid && (!res_valid || !m_tvalid_reg || m_tready);
    assign s_tready  = !item_valid || retire;
    assign in_accept = s_tvalid && s_tready;
    assign load      = retire && res_valid;

    // output register
    always_comb begin
        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tuser_reg <= result.found;
            m_tdata_reg <= M_TDATA_W'({result.captured_word, result.match_offset});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### design/mbps_checker.sv
// ----------------------------------------------------------------------------
// mbps_checker
// Port-level checks of the masked byte pattern scan, bound to the top level.
// ----------------------------------------------------------------------------
module mbps_checker
    import mbps_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic                  m_tuser,
    input logic [M_TDATA_W-1:0]  m_tdata
);

    // a held result keeps its contents
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a not-found transaction carries zero offset and word
    a_notfound_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("not-found result with nonzero fields");

    // input stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

endmodule

bind masked_byte_pattern_scan mbps_checker u_mbps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
);

### sim/masked_byte_pattern_scan_test.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_test
// Self-checking bench for the masked byte pattern scan. A directed tour covers
// reset defaults, wildcard nibbles, length and capture extremes and matches on
// the final byte. Random phases then reprogram every register and stream
// regions that mostly carry an embedded pattern. Expected results come from a
// local shadow of the scanner and are checked in order against the output
// stream, with random idle bursts on both sides.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scan_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mbps_pkg::*;

    localparam int unsigned ITEM_GOAL      = 1250;
    localparam int unsigned CALM_ITEMS     = 200;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned REPORT_LIMIT   = 10;
    // call signature 0E 8B 83 E9, first byte lowest
    localparam logic [63:0] CALL_SIG       = 64'h0000_0000_E983_8B0E;

    typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;
    typedef enum logic [1:0] {CHECK_MODEL, PIN_NOTHING, PIN_FOUND, PIN_NOT_FOUND} pin_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [63:0]           value;
        logic                  last;
        pin_t                  pin;
        logic [OFFSET_W-1:0]   off;
        logic [WORD_W-1:0]     word;
    } tour_row_t;

    typedef struct {
        pin_t         pin;
        mbps_result_t exp;
    } byte_note_t;

    // clock, reset and block ports
    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // byte_value [7:0]
    logic                  s_tlast   = 1'b0; // last_byte
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  m_tuser;          // found
    logic [M_TDATA_W-1:0]  m_tdata;          // match_offset [31:0],
                                             // captured_word [47:32]
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // shadow configuration
    logic [63:0]           pat_word [4] = '{default: '0};
    logic [63:0]           care_bits    = '0;
    logic [5:0]            len_reg      = 6'd1;
    logic [4:0]            adjust_reg   = '0;
    logic [4:0]            capture_reg  = '0;

    // shadow scan state
    logic [7:0]            win_bytes [PATTERN_MAX] = '{default: '0};
    logic [31:0]           run_pos  = '0;
    logic                  run_hit  = 1'b0;
    int unsigned           win_fill = 0;

    mbps_result_t          pending_results [$];
    byte_note_t            byte_notes [$];
    int unsigned           errors     = 0;
    logic [63:0]           plan [8];
    logic                  calm       = 1'b0;
    int unsigned           gap_odds   = 6;
    int unsigned           stall_odds = 6;
    int unsigned           hold_left  = 0;

    // directed tour: byte rows carry the byte in value[7:0]
    tour_row_t tour [39] = '{
        // reset defaults: one wildcard byte matches at the region start
        '{ROW_BYTE, '0, 64'h00, 1'b0, PIN_FOUND,     32'd0,  16'h0000},
        '{ROW_BYTE, '0, 64'hFF, 1'b0, PIN_NOTHING,   32'd0,  16'h0000},
        '{ROW_BYTE, '0, 64'h5A, 1'b1, PIN_NOTHING,   32'd0,  16'h0000},
        '{ROW_BYTE, '0, 64'hA5, 1'b1, PIN_FOUND,     32'd0,  16'h00A5},
        // exact signature, top adjust, capture past the pattern
        '{ROW_CFG, REG_PATTERN_0,      CALL_SIG, 1'b0, CHECK_MODEL, 32'd0, 16'h0},
        '{ROW_CFG, REG_CARE_NIBBLES,   64'hFF,   1'b0, CHECK_MODEL, 32'd0, 16'h0},
        '{ROW_CFG, REG_PATTERN_LENGTH, 64'd4,    1'b0, CHECK_MODEL, 32'd0, 16'h0},
        '{ROW_CFG, REG_REPORT_ADJUST,  64'd31,   1'b0, CHECK_MODEL, 32'd0, 16'h0},
        '{ROW_CFG, REG_CAPTURE_OFFSET, 64'd30,   1'b0, CHECK_MODEL, 32'd0, 16'h0},
        '{ROW_BYTE, '0, 64'h0E, 1'b0, CHECK_MODEL,   32'd0,  16'h0000},
        '{ROW_BYTE, '0, 64'h0E, 1'b0, CHECK_MODEL,   32'd0,  16'h0000},
        '{ROW_BYTE, '0, 64'h8B, 1'b0, CHECK_MODEL,   32'd0,  16'h0000},
        '{ROW_BYTE, '0, 64'h83, 1'b0, CHECK_MODEL,   32'd0,  16'h0000},
        '{ROW_BYTE, '0, 64'hE9, 1'b1, PIN_FOUND,     32'd32, 16'h0000},
        // signature cut off by the region end
        '{ROW_BYTE, '0, 64'h0E, 1'b0, CHECK_MODEL,   32'd0,  16'h0000},
        '{ROW_BYTE, '0, 64'h8B, 1'b0, CHECK_MODEL,   32'd0,  16'h0000},
        '{ROW_BYTE, '0, 64'h83, 1'b1, PIN_NOT_FOUND, 32'd0,  16'h0000},
        // high nibble wildcards on pattern bytes 1 and 2
        '{ROW_CFG, REG_CARE_NIBBLES,   64'hD7,   1'b0, CHECK_MODEL, 32'd0, 16'h0},
        '{ROW_CFG, REG_REPORT_ADJUST,  64'd0,    1'b0, CHECK_MODEL, 32'd0, 16'h0},
        '{ROW_CFG, REG_CAPTURE_OFFSET, 64'd1,    1'b0, CHECK_MODEL, 32'd0, 16'h0},
        '{ROW_BYTE, '0, 64'h0E, 1'b0, CHECK_MODEL,   32'd0,  16'h0000},
        '{ROW_BYTE, '0, 64'h3B, 1'b0, CHECK_MODEL,   32'd0,  16'h0000},
        '{ROW_BYTE, '0, 64'hF3, 1'b0, CHECK_MODEL,   32'd0,  16'h0000},
        '{ROW_BYTE, '0, 64'hE9, 1'b0, CHECK_MODEL,   32'd0,  16'h0000},
        '{ROW_BYTE, '0, 64'h00, 1'b1, CHECK_MODEL,   32'd0,  16'h0000},
        // oversized length clamps to the full window
        '{ROW_CFG, REG_PATTERN_0,      '1,       1'b0, CHECK_MODEL, 32'd0, 16'h0},
        '{ROW_CFG, REG_PATTERN_1,      '1,       1'b0, CHECK_MODEL, 32'd0, 16'h0},
        '{ROW_CFG, REG_PATTERN_2,      '1,       1'b0, CHECK_MODEL, 32'd0, 16'h0},
        '{ROW_CFG, REG_PATTERN_3,      '1,       1'b0, CHECK_MODEL, 32'd0, 16'h0},
        '{ROW_CFG, REG_CARE_NIBBLES,   '1,       1'b0, CHECK_MODEL, 32'd0, 16'h0},
        '{ROW_CFG, REG_PATTERN_LENGTH, 64'd63,   1'b0, CHECK_MODEL, 32'd0, 16'h0},
        '{ROW_BYTE, '0, 64'hFF, 1'b0, CHECK_MODEL,   32'd0,  16'h0000},
        '{ROW_BYTE, '0, 64'hFF, 1'b0, CHECK_MODEL,   32'd0,  16'h0000},
        '{ROW_BYTE, '0, 64'hFF, 1'b1, PIN_NOT_FOUND, 32'd0,  16'h0000},
        // zero length acts as one byte
        '{ROW_CFG, REG_PATTERN_LENGTH, 64'd0,    1'b0, CHECK_MODEL, 32'd0, 16'h0},
        '{ROW_CFG, REG_CARE_NIBBLES,   64'h3,    1'b0, CHECK_MODEL, 32'd0, 16'h0},
        '{ROW_BYTE, '0, 64'h7F, 1'b0, CHECK_MODEL,   32'd0,  16'h0000},
        '{ROW_BYTE, '0, 64'hFF, 1'b1, CHECK_MODEL,   32'd0,  16'h0000},
        '{ROW_BYTE, '0, 64'hFF, 1'b1, CHECK_MODEL,   32'd0,  16'h0000}
    };

    masked_byte_pattern_scan dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // byte at pattern position k of the candidate ending at the newest byte
    function automatic logic [7:0] tap_at(int unsigned k, int unsigned len);
        if (k >= len) return 8'h00;
        return win_bytes[len - 1 - k];
    endfunction

    // shift one byte into the shadow window and work out its result
    function automatic void scan_byte(input logic [7:0] b, input logic last,
                                      output logic hit, output mbps_result_t res);
        int unsigned len;
        int unsigned i;
        logic [7:0]  care;
        logic [7:0]  want;
        logic        ok;
        len = (len_reg == 0) ? 1 : ((len_reg > PATTERN_MAX) ? PATTERN_MAX : len_reg);
        for (i = PATTERN_MAX - 1; i > 0; i--) win_bytes[i] = win_bytes[i - 1];
        win_bytes[0] = b;
        if (win_fill < PATTERN_MAX) win_fill++;
        hit = 1'b0;
        res = '0;
        // masked compare over the pattern length
        ok = !run_hit && (win_fill >= len);
        for (i = 0; i < len && ok; i++) begin
            care = {{4{care_bits[2 * i + 1]}}, {4{care_bits[2 * i]}}};
            want = pat_word[i / 8][(i % 8) * 8 +: 8];
            if (((tap_at(i, len) ^ want) & care) != 8'h00) ok = 1'b0;
        end
        if (ok) begin
            res.found         = 1'b1;
            res.match_offset  = run_pos - (len - 1) + adjust_reg;
            res.captured_word = {tap_at(int'(capture_reg) + 1, len),
                                 tap_at(int'(capture_reg), len)};
            run_hit = 1'b1;
            hit     = 1'b1;
        end
        run_pos++;
        // region end: report a miss if nothing was found, then rearm
        if (last) begin
            if (!hit && !run_hit) hit = 1'b1;
            run_pos  = '0;
            run_hit  = 1'b0;
            win_fill = 0;
        end
    endfunction

    // track register writes, predict accepted bytes, check results
    always @(posedge aclk) begin : track
        byte_note_t   note;
        logic         hit;
        mbps_result_t res;
        mbps_result_t got;
        mbps_result_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PATTERN_0, REG_PATTERN_1, REG_PATTERN_2, REG_PATTERN_3:
                        pat_word[cfg_index[1:0]] = cfg_data;
                    REG_CARE_NIBBLES:   care_bits   = cfg_data;
                    REG_PATTERN_LENGTH: len_reg     = cfg_data[5:0];
                    REG_REPORT_ADJUST:  adjust_reg  = cfg_data[4:0];
                    REG_CAPTURE_OFFSET: capture_reg = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                note.pin = CHECK_MODEL;
                note.exp = '0;
                if (byte_notes.size() != 0) note = byte_notes.pop_front();
                scan_byte(s_tdata, s_tlast, hit, res);
                case (note.pin)
                    PIN_NOTHING:   hit = 1'b0;
                    PIN_FOUND, PIN_NOT_FOUND: begin
                        hit = 1'b1;
                        res = note.exp;
                    end
                    default: ;
                endcase
                if (hit) pending_results.push_back(res);
            end
            if (m_tvalid && m_tready) begin
                got.found         = m_tuser;
                got.match_offset  = m_tdata[OFFSET_W-1:0];
                got.captured_word = m_tdata[OFFSET_W +: WORD_W];
                if (pending_results.size() == 0) begin
                    if (errors < REPORT_LIMIT)
                        $display("unexpected result: found %0d offset %08h word %04h",
                                 got.found, got.match_offset, got.captured_word);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.found !== want.found || got.match_offset !== want.match_offset ||
                        got.captured_word !== want.captured_word) begin
                        if (errors < REPORT_LIMIT) begin
                            $display("result mismatch (expected/actual):");
                            $display("  found %0d/%0d offset %08h/%08h word %04h/%04h",
                                     want.found, got.found, want.match_offset,
                                     got.match_offset, want.captured_word, got.captured_word);
                        end
                        errors++;
                    end
                end
            end
        end
    end

    // result side back-pressure in random bursts
    always @(posedge aclk) begin
        if (hold_left != 0 && !calm) begin
            hold_left <= hold_left - 1;
        end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            m_tready  <= 1'b0;
            hold_left <= $urandom_range(0, 15);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no transaction at all
    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("masked_byte_pattern_scan_test: done, errors");
        $finish;
    end

    // one byte transaction, with an optional idle burst ahead of it
    task automatic send_byte(input logic [7:0] b, input logic last, input pin_t pin,
                             input mbps_result_t exp);
        byte_note_t note;
        if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        note.pin = pin;
        note.exp = exp;
        byte_notes.push_back(note);
        s_tdata  <= b;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    // register write transaction; valid stays up for back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
    endtask

    // stop sending and wait until the block has nothing left in flight
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0 || byte_notes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // random register set for one phase, lengths mostly short
    task automatic pick_plan();
        int unsigned r;
        plan[REG_PATTERN_0] = {$urandom, $urandom};
        plan[REG_PATTERN_1] = {$urandom, $urandom};
        plan[REG_PATTERN_2] = {$urandom, $urandom};
        plan[REG_PATTERN_3] = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       plan[REG_CARE_NIBBLES] = '1;
            1:       plan[REG_CARE_NIBBLES] = '0;
            default: plan[REG_CARE_NIBBLES] = {$urandom, $urandom} | {$urandom, $urandom};
        endcase
        r = $urandom_range(0, 19);
        if (r == 0)      plan[REG_PATTERN_LENGTH] = 64'd0;
        else if (r == 1) plan[REG_PATTERN_LENGTH] = 64'($urandom_range(33, 63));
        else if (r < 4)  plan[REG_PATTERN_LENGTH] = 64'(PATTERN_MAX);
        else if (r < 8)  plan[REG_PATTERN_LENGTH] = 64'($urandom_range(9, 31));
        else             plan[REG_PATTERN_LENGTH] = 64'($urandom_range(1, 8));
        plan[REG_REPORT_ADJUST]  = 64'($urandom_range(0, 31));
        plan[REG_CAPTURE_OFFSET] = 64'($urandom_range(0, 30));
        gap_odds   = (r % 4 == 0) ? 0 : $urandom_range(2, 12);
        stall_odds = (r % 3 == 0) ? 0 : $urandom_range(2, 12);
    endtask

    // write every register of the plan, then close the channel
    task automatic program_plan();
        int i;
        for (i = 0; i < 8; i++) write_reg(CFG_IDX_W'(i), plan[i]);
        cfg_valid <= 1'b0;
    endtask

    // one region: whole, cut short or spoiled pattern copies in random bytes
    task automatic run_region(output int unsigned sent);
        logic [7:0]  region [128];
        logic [7:0]  care;
        logic [7:0]  want;
        int unsigned eff;
        int unsigned rlen;
        int unsigned start;
        int unsigned k;
        int unsigned style;
        eff = 32'(plan[REG_PATTERN_LENGTH][5:0]);
        if (eff == 0) eff = 1;
        if (eff > PATTERN_MAX) eff = PATTERN_MAX;
        style = $urandom_range(0, 9);
        rlen  = ($urandom_range(0, 9) == 0) ? $urandom_range(eff, 90)
                                             : $urandom_range(1, eff + 10);
        for (k = 0; k < rlen; k++) region[k] = 8'($urandom_range(0, 255));
        if (style < 8) begin
            if (rlen < eff)      start = 0;
            else if (style == 6) start = rlen - eff + 1;
            else                 start = $urandom_range(0, rlen - eff);
            for (k = 0; k < eff && start + k < rlen; k++) begin
                care = {{4{plan[REG_CARE_NIBBLES][2 * k + 1]}},
                        {4{plan[REG_CARE_NIBBLES][2 * k]}}};
                want = plan[REG_PATTERN_0 + k / 8][(k % 8) * 8 +: 8];
                region[start + k] = (want & care) | (region[start + k] & ~care);
            end
            // flip one bit inside the copy
            if (style == 7) begin
                k = start + $urandom_range(0, eff - 1);
                if (k < rlen) region[k] ^= 8'h01 << $urandom_range(0, 7);
            end
        end
        for (k = 0; k < rlen; k++) send_byte(region[k], k == rlen - 1, CHECK_MODEL, '0);
        sent = rlen;
    endtask

    // reset, directed tour, random phases, drain and verdict
    initial begin
        int           i;
        logic         cfg_open;
        mbps_result_t pinned;
        int unsigned  random_sent;
        int unsigned  phase_sent;
        int unsigned  phase_goal;
        int unsigned  n;
        repeat (4) @(posedge aclk);
        aresetn  <= 1'b1;
        cfg_open = 1'b0;
        for (i = 0; i < $size(tour); i++) begin
            if (tour[i].kind == ROW_CFG) begin
                if (!cfg_open) begin
                    settle();
                    cfg_open = 1'b1;
                end
                write_reg(tour[i].idx, tour[i].value);
            end else begin
                if (cfg_open) begin
                    cfg_valid <= 1'b0;
                    cfg_open  = 1'b0;
                end
                pinned.found         = (tour[i].pin == PIN_FOUND);
                pinned.match_offset  = tour[i].off;
                pinned.captured_word = tour[i].word;
                send_byte(tour[i].value[7:0], tour[i].last, tour[i].pin, pinned);
            end
        end
        random_sent = 0;
        while (random_sent < ITEM_GOAL) begin
            settle();
            pick_plan();
            program_plan();
            phase_goal = $urandom_range(60, 140);
            phase_sent = 0;
            while (phase_sent < phase_goal && random_sent < ITEM_GOAL) begin
                run_region(n);
                phase_sent  += n;
                random_sent += n;
                if (random_sent + CALM_ITEMS >= ITEM_GOAL) calm = 1'b1;
            end
        end
        settle();
        if (errors == 0 && pending_results.size() == 0)
            $display("masked_byte_pattern_scan_test: done, clean");
        else
            $display("masked_byte_pattern_scan_test: done, errors");
        $finish;
    end

endmodule

### masked_byte_pattern_scan.f
design/mbps_pkg.sv
design/mbps_cfg.sv
design/mbps_scan.sv
design/masked_byte_pattern_scan.sv
design/mbps_checker.sv
sim/masked_byte_pattern_scan_test.sv
